// ===== hw/rtl/gsp_pkg.sv =====
package gsp_pkg;

    // Depth of the queue between the classifying front and the output back end.
    localparam int unsigned GSP_QUEUE_DEPTH = 4;
    localparam int unsigned GSP_QUEUE_AW    = $clog2(GSP_QUEUE_DEPTH);
    localparam int unsigned GSP_QUEUE_CW    = $clog2(GSP_QUEUE_DEPTH + 1);

    localparam logic [6:0] GSP_SEPTET_MASK = 7'h7f;

    // Group position at which an unpack group ends with a second septet.
    localparam logic [2:0] GSP_UNPACK_LAST_POS = 3'd6;
    localparam logic [2:0] GSP_POS_WRAP        = 3'd7;

    // Values of the direction register.
    localparam logic GSP_DIR_PACK   = 1'b0;
    localparam logic GSP_DIR_UNPACK = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } t_gsp_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_gsp_out;

    // One queued input item: one or two results ready to be sent.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [6:0] second;
    } t_gsp_entry;

endpackage

// ===== hw/rtl/gsp_front.sv =====
module gsp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gsp_pkg::t_gsp_in      i_in_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output gsp_pkg::t_gsp_entry   o_q_entry
);

    logic       r_direction;
    logic       n_direction;
    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [6:0] r_carry;
    logic [6:0] n_carry;

    logic                accept;
    logic [6:0]          c_char;
    logic [15:0]         pack_wide;
    logic [2:0]          up_pos;
    logic [14:0]         up_wide;
    logic [7:0]          up_rest;
    logic [6:0]          up_first;
    logic [6:0]          up_carry;
    logic                has_result;
    gsp_pkg::t_gsp_entry entry;
    logic [2:0]          calc_pos;
    logic [6:0]          calc_carry;

    assign accept      = i_in_valid && !i_q_full;
    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;

    assign c_char    = i_in_data.data_byte[6:0];
    assign pack_wide = {9'b0, c_char} << (4'd8 - {1'b0, r_pos});

    assign up_pos   = (r_pos == gsp_pkg::GSP_POS_WRAP) ? 3'd0 : r_pos;
    assign up_wide  = {7'b0, i_in_data.data_byte} << up_pos;
    assign up_first = up_wide[6:0] | r_carry;
    assign up_rest  = i_in_data.data_byte >> (3'd7 - up_pos);
    assign up_carry = up_rest[6:0] & gsp_pkg::GSP_SEPTET_MASK;

    always_comb begin
        entry      = '0;
        has_result = 1'b0;
        calc_pos   = r_pos + 3'd1;
        calc_carry = r_carry;
        if (r_direction == gsp_pkg::GSP_DIR_PACK) begin
            if (r_pos == 3'd0) begin
                // The first character of a group only loads the carry.
                calc_carry = c_char;
            end else begin
                has_result  = 1'b1;
                entry.first = pack_wide[7:0] | {1'b0, r_carry};
                calc_carry  = c_char >> r_pos;
            end
        end else begin
            has_result  = 1'b1;
            entry.first = {1'b0, up_first};
            if (up_pos == gsp_pkg::GSP_UNPACK_LAST_POS) begin
                entry.two    = 1'b1;
                entry.second = up_carry;
                calc_pos     = 3'd0;
                calc_carry   = '0;
            end else begin
                calc_pos   = up_pos + 3'd1;
                calc_carry = up_carry;
            end
        end
    end

    always_comb begin
        n_direction = r_direction;
        n_pos       = r_pos;
        n_carry     = r_carry;
        if (i_cfg_valid) begin
            n_direction = i_cfg_data;
        end
        if (accept) begin
            if (i_in_data.message_end) begin
                n_pos   = '0;
                n_carry = '0;
            end else begin
                n_pos   = calc_pos;
                n_carry = calc_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= gsp_pkg::GSP_DIR_PACK;
            r_pos       <= '0;
            r_carry     <= '0;
        end else begin
            r_direction <= n_direction;
            r_pos       <= n_pos;
            r_carry     <= n_carry;
        end
    end

    assign o_q_push  = accept && has_result;
    assign o_q_entry = entry;

`ifndef NO_ASSERTIONS
    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (i_in_valid && !i_q_full))
        else $error("queue push without an accepted item");

    a_unpack_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_direction == gsp_pkg::GSP_DIR_UNPACK) |=> (r_pos != gsp_pkg::GSP_POS_WRAP))
        else $error("unpack left group position at seven");
`endif

endmodule

// ===== hw/rtl/gsp_queue.sv =====
module gsp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  gsp_pkg::t_gsp_entry   i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output gsp_pkg::t_gsp_entry   o_entry
);

    gsp_pkg::t_gsp_entry r_slot [gsp_pkg::GSP_QUEUE_DEPTH];

    logic [gsp_pkg::GSP_QUEUE_AW-1:0] r_wr_ptr;
    logic [gsp_pkg::GSP_QUEUE_AW-1:0] n_wr_ptr;
    logic [gsp_pkg::GSP_QUEUE_AW-1:0] r_rd_ptr;
    logic [gsp_pkg::GSP_QUEUE_AW-1:0] n_rd_ptr;
    logic [gsp_pkg::GSP_QUEUE_CW-1:0] r_count;
    logic [gsp_pkg::GSP_QUEUE_CW-1:0] n_count;

    assign o_full  = (r_count == gsp_pkg::GSP_QUEUE_CW'(gsp_pkg::GSP_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == gsp_pkg::GSP_QUEUE_AW'(gsp_pkg::GSP_QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == gsp_pkg::GSP_QUEUE_AW'(gsp_pkg::GSP_QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");
`endif

endmodule

// ===== hw/rtl/gsp_back.sv =====
module gsp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  gsp_pkg::t_gsp_entry   i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gsp_pkg::t_gsp_out     o_out_data
);

    logic                r_out_valid;
    logic                n_out_valid;
    gsp_pkg::t_gsp_out   r_out_data;
    gsp_pkg::t_gsp_out   n_out_data;
    // Set while the first of two results of the head entry has been sent.
    logic                r_half;
    logic                n_half;
    logic                load;

    assign load = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_half      = r_half;
        o_q_pop     = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            if (i_q_entry.two && !r_half) begin
                n_out_data.out_byte = i_q_entry.first;
                n_out_data.run_last = 1'b0;
                n_half              = 1'b1;
            end else if (i_q_entry.two) begin
                n_out_data.out_byte = {1'b0, i_q_entry.second};
                n_out_data.run_last = 1'b1;
                n_half              = 1'b0;
                o_q_pop             = 1'b1;
            end else begin
                n_out_data.out_byte = i_q_entry.first;
                n_out_data.run_last = 1'b1;
                o_q_pop             = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_half      <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_half_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_q_valid && i_q_entry.two))
        else $error("second half pending without a two-result head entry");

    a_half_then_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_half) |-> (r_out_valid && !r_out_data.run_last))
        else $error("first of two results marked as last");
`endif

endmodule

// ===== hw/rtl/gsm_septet_pack_unpack_unit.sv =====
// GSM 7-bit septet packer and unpacker for a byte stream. The direction
// register (reset 0) selects pack mode, where every group of eight 7-bit
// characters becomes seven octets, or unpack mode (1), where every octet
// gives one character and the seventh octet of a group gives a second one
// from the carry. The first character of a pack group yields no result; pack
// mode never flushes its carry, so a sender appends a zero character to push
// out the last partial bits. An input transfer with message_end set clears
// the group position and the carry once it is processed. Bit 7 of a pack
// character is ignored. run_last marks the final result of each input item.
// Input transfers are taken one per cycle while the four-entry queue between
// the classifying front end and the output stage has room; the output stage
// sends one result per cycle unless the receiver stalls, so a seventh unpack
// octet occupies it for two results; each result passes the queue and then
// the output register. The direction register is written through its own
// valid/ready port, which is always ready; write it only while no item is
// in flight. Changing the direction does not reset the stream position.
module gsm_septet_pack_unpack_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gsp_pkg::t_gsp_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gsp_pkg::t_gsp_out   o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    // Queue between the front end and the output stage.
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    gsp_pkg::t_gsp_entry q_in_entry;
    gsp_pkg::t_gsp_entry q_out_entry;

    // The front end holds the direction, group position and carry, and turns
    // each accepted transfer into zero, one or two results.
    gsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in_entry)
    );

    gsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out_entry)
    );

    // The output stage splits two-result entries and holds each result in a
    // register until the receiver takes it.
    gsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_out_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
